@@ hdl/pid_integral_separation_assert.svh @@
// Assertion macros for the PID integral separation block
`ifndef PID_INTEGRAL_SEPARATION_ASSERT_SVH
`define PID_INTEGRAL_SEPARATION_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define PIS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pis assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define PIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pis assertion failed");

`endif

@@ hdl/pis_pkg.sv @@
// Shared types and constants for the PID integral separation block
`default_nettype none
package pis_pkg;

  localparam int ERROR_WIDTH_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int GAIN_W      = 16;
  localparam int CLAMP_W     = 31;
  localparam int BAND_W      = 16;
  localparam int INTEG_W     = 32;
  localparam int DRIVE_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_KP    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KI    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KD    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ICLAMP = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DCLAMP = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND  = 3'd5;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [CLAMP_W-1:0] integral_clamp;
    logic [CLAMP_W-1:0] drive_clamp;
    logic [BAND_W-1:0]  separation_band;
  } cfg_t;

endpackage
`default_nettype wire

@@ hdl/pid_integral_separation.sv @@
// Pipeline: an accepted sample moves through a_valid, b_valid and m_tvalid (3 registers).
// Throughput: one error sample per cycle while not stalled; integral update is registered.
// Each stage advances on its own ready, so input is taken while a result waits, up to 3 held.
// Reset (rst, synchronous): clears registers, previous error, integral and stage valids.
`default_nettype none
module pid_integral_separation
  import pis_pkg::*;
#(
  parameter int ERROR_WIDTH    = ERROR_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [((ERROR_WIDTH+7)/8)*8-1:0]     s_tdata,   // error
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [DRIVE_W-1:0]                        m_tdata,   // drive
  output logic                                      m_tuser,   // integral_used
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]               cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                cfg_data
);

  cfg_t cfg;

  logic                                a_valid;
  logic                                a_ready;
  logic signed [ERROR_WIDTH-1:0]       a_error;
  logic signed [ERROR_WIDTH:0]         a_diff;
  logic signed [INTEG_W-1:0]           a_integ;
  logic                                a_used;

  logic                                b_valid;
  logic                                b_ready;
  logic signed [GAIN_W+ERROR_WIDTH-1:0] b_p;
  logic signed [GAIN_W+INTEG_W-1:0]    b_i;
  logic signed [GAIN_W+ERROR_WIDTH:0]  b_d;
  logic                                b_used;

  pis_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pis_integ #(.ERROR_WIDTH(ERROR_WIDTH)) u_integ (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_error   (signed'(s_tdata[ERROR_WIDTH-1:0])),
    .a_valid    (a_valid),
    .a_ready_dn (a_ready),
    .a_error    (a_error),
    .a_diff     (a_diff),
    .a_integ    (a_integ),
    .a_used     (a_used)
  );

  pis_mult #(.ERROR_WIDTH(ERROR_WIDTH)) u_mult (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .a_valid    (a_valid),
    .a_ready    (a_ready),
    .a_error    (a_error),
    .a_diff     (a_diff),
    .a_integ    (a_integ),
    .a_used     (a_used),
    .b_valid    (b_valid),
    .b_ready_dn (b_ready),
    .b_p        (b_p),
    .b_i        (b_i),
    .b_d        (b_d),
    .b_used     (b_used)
  );

  pis_out #(
    .ERROR_WIDTH    (ERROR_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .b_valid  (b_valid),
    .b_ready  (b_ready),
    .b_p      (b_p),
    .b_i      (b_i),
    .b_d      (b_d),
    .b_used   (b_used),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

@@ hdl/pis_cfg.sv @@
// Configuration register file
`default_nettype none
module pis_cfg
  import pis_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KP:     cfg.kp <= cfg_data[GAIN_W-1:0];
        REG_KI:     cfg.ki <= cfg_data[GAIN_W-1:0];
        REG_KD:     cfg.kd <= cfg_data[GAIN_W-1:0];
        REG_ICLAMP: cfg.integral_clamp <= cfg_data[CLAMP_W-1:0];
        REG_DCLAMP: cfg.drive_clamp <= cfg_data[CLAMP_W-1:0];
        REG_BAND:   cfg.separation_band <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/pis_integ.sv @@
// Input stage: separation test, saturating integral, derivative difference
`default_nettype none
module pis_integ
  import pis_pkg::*;
#(
  parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cfg_t                          cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [ERROR_WIDTH-1:0] in_error,
  output logic                               a_valid,
  input  wire logic                          a_ready_dn,
  output logic signed [ERROR_WIDTH-1:0]      a_error,
  output logic signed [ERROR_WIDTH:0]        a_diff,
  output logic signed [INTEG_W-1:0]          a_integ,
  output logic                               a_used
);

  localparam int MW = ((ERROR_WIDTH > BAND_W) ? ERROR_WIDTH : BAND_W) + 1;

  logic signed [ERROR_WIDTH-1:0] previous_error;
  logic signed [INTEG_W-1:0]     integral_sum;
  logic signed [INTEG_W-1:0]     integral_sum_next;

  logic signed [MW-1:0]      e_w;
  logic        [MW-1:0]      mag;
  logic                      ki_on;
  logic                      used;
  logic signed [INTEG_W:0]   sum;
  logic signed [INTEG_W:0]   acc;
  logic signed [INTEG_W:0]   lim;
  logic                      accept;

  assign in_ready = !a_valid || a_ready_dn;
  assign accept   = in_valid && in_ready;

  always_comb begin
    e_w   = MW'(in_error);
    mag   = (e_w < 0) ? MW'(-e_w) : MW'(e_w);
    ki_on = (cfg.ki != '0);
    used  = ki_on && ((cfg.separation_band == '0) || (mag <= MW'(cfg.separation_band)));
    sum   = (INTEG_W+1)'(integral_sum) + (INTEG_W+1)'(in_error);
    if (!used) begin
      acc = (INTEG_W+1)'(integral_sum);
    end else if (sum[INTEG_W] != sum[INTEG_W-1]) begin
      acc = sum[INTEG_W] ? {2'b11, {(INTEG_W-1){1'b0}}} : {2'b00, {(INTEG_W-1){1'b1}}};
    end else begin
      acc = sum;
    end
    lim = signed'({2'b00, cfg.integral_clamp});
    if (cfg.integral_clamp != '0) begin
      if (acc > lim) begin
        acc = lim;
      end else if (acc < -lim) begin
        acc = -lim;
      end
    end
    integral_sum_next = acc[INTEG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      previous_error <= '0;
      integral_sum   <= '0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (accept) begin
        previous_error <= in_error;
        if (ki_on) begin
          integral_sum <= integral_sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_error <= in_error;
      a_diff  <= (ERROR_WIDTH+1)'(in_error) - (ERROR_WIDTH+1)'(previous_error);
      a_integ <= used ? integral_sum_next : '0;
      a_used  <= used;
    end
  end

endmodule
`default_nettype wire

@@ hdl/pis_mult.sv @@
// Product stage: the three gain multiplications
`default_nettype none
module pis_mult
  import pis_pkg::*;
#(
  parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cfg_t                              cfg,
  input  wire logic                              a_valid,
  output logic                                   a_ready,
  input  wire logic signed [ERROR_WIDTH-1:0]     a_error,
  input  wire logic signed [ERROR_WIDTH:0]       a_diff,
  input  wire logic signed [INTEG_W-1:0]         a_integ,
  input  wire logic                              a_used,
  output logic                                   b_valid,
  input  wire logic                              b_ready_dn,
  output logic signed [GAIN_W+ERROR_WIDTH-1:0]   b_p,
  output logic signed [GAIN_W+INTEG_W-1:0]       b_i,
  output logic signed [GAIN_W+ERROR_WIDTH:0]     b_d,
  output logic                                   b_used
);

  assign a_ready = !b_valid || b_ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      b_p    <= $signed(cfg.kp) * a_error;
      b_i    <= $signed(cfg.ki) * a_integ;
      b_d    <= $signed(cfg.kd) * a_diff;
      b_used <= a_used;
    end
  end

endmodule
`default_nettype wire

@@ hdl/pis_out.sv @@
// Output stage: sum, scale, clamp and result register
`default_nettype none
module pis_out
  import pis_pkg::*;
#(
  parameter int ERROR_WIDTH    = ERROR_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cfg_t                              cfg,
  input  wire logic                              b_valid,
  output logic                                   b_ready,
  input  wire logic signed [GAIN_W+ERROR_WIDTH-1:0] b_p,
  input  wire logic signed [GAIN_W+INTEG_W-1:0]  b_i,
  input  wire logic signed [GAIN_W+ERROR_WIDTH:0] b_d,
  input  wire logic                              b_used,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [DRIVE_W-1:0]                     m_tdata,
  output logic                                   m_tuser
);

  localparam int PW = (GAIN_W + ERROR_WIDTH + 1 > GAIN_W + INTEG_W) ?
                      GAIN_W + ERROR_WIDTH + 1 : GAIN_W + INTEG_W;
  localparam int SW = PW + 2;

  logic signed [SW-1:0] raw;
  logic signed [SW-1:0] scaled;
  logic signed [SW-1:0] lim;
  logic signed [SW-1:0] smax;
  logic signed [SW-1:0] smin;
  logic signed [SW-1:0] drive;

  assign b_ready = !m_tvalid || m_tready;

  always_comb begin
    raw    = SW'(b_p) + SW'(b_i) + SW'(b_d);
    scaled = raw >>> GAIN_FRAC_BITS;
    lim    = SW'(signed'({1'b0, cfg.drive_clamp}));
    smax   = SW'(signed'({1'b0, {(DRIVE_W-1){1'b1}}}));
    smin   = -smax - SW'(1);
    drive  = scaled;
    if (cfg.drive_clamp != '0) begin
      if (scaled > lim) begin
        drive = lim;
      end else if (scaled < -lim) begin
        drive = -lim;
      end
    end else begin
      if (scaled > smax) begin
        drive = smax;
      end else if (scaled < smin) begin
        drive = smin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_ready) begin
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_ready) begin
      m_tdata <= drive[DRIVE_W-1:0];
      m_tuser <= b_used;
    end
  end

endmodule
`default_nettype wire

@@ hdl/pis_checker.sv @@
// Port-level assertions for the PID integral separation block, with bind
`default_nettype none
`include "pid_integral_separation_assert.svh"
module pis_checker
  import pis_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tvalid,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [DRIVE_W-1:0] m_tdata,
  input wire logic               m_tuser,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);

  // a stalled result transaction holds its payload
  `PIS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // empty output register means the whole pipe can take input
  `PIS_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready)
  // a draining output lets every stage advance
  `PIS_ASSERT_NOW(a_drain_ready, m_tready, s_tready)
  // register writes are never back-pressured
  `PIS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

  logic unused_s_tvalid;
  assign unused_s_tvalid = s_tvalid;

endmodule

bind pid_integral_separation pis_checker u_pis_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

@@ sim/pid_integral_separation_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for pid_integral_separation: streamed samples, PID prediction
module pid_integral_separation_tb;
  import pis_pkg::*;

  localparam int ERR_W          = ERROR_WIDTH_DEF;
  localparam int ERR_BUS_W      = ((ERR_W + 7) / 8) * 8;
  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_CAP     = 50;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               integral_used;
  } pid_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [ERR_BUS_W-1:0]   s_tdata = '0;    // error
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [DRIVE_W-1:0]     m_tdata;         // drive
  logic                   m_tuser;         // integral_used
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of registers and state
  logic [GAIN_W-1:0]         kp_gain = '0;
  logic [GAIN_W-1:0]         ki_gain = '0;
  logic [GAIN_W-1:0]         kd_gain = '0;
  logic [CLAMP_W-1:0]        integral_clamp = '0;
  logic [CLAMP_W-1:0]        drive_clamp = '0;
  logic [BAND_W-1:0]         separation_band = '0;
  logic signed [ERR_W-1:0]   prev_error = '0;
  logic signed [INTEG_W-1:0] integral_sum = '0;

  logic [ERR_W-1:0] error_backlog[$];
  pid_result_t      drive_due[$];
  int               idle_pct = 26;
  logic             stall_req = 1'b0;
  int               stall_left = 0;
  int               quiet_cycles = 0;
  int               fail_count = 0;

  pid_integral_separation dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= REPORT_CAP) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic void pid_predict(input logic [ERR_W-1:0] sample);
    longint      e;
    longint      integ;
    longint      mag;
    longint      iterm;
    longint      raw;
    longint      drv;
    bit          used;
    pid_result_t r;
    e = longint'($signed(sample));
    integ = longint'(integral_sum);
    iterm = 0;
    used = 1'b0;
    if (ki_gain != '0) begin
      mag = (e < 0) ? -e : e;
      if (separation_band == '0 || mag <= longint'(separation_band)) begin
        used = 1'b1;
        integ = integ + e;
        if (integ > S32_MAX) integ = S32_MAX;
        if (integ < S32_MIN) integ = S32_MIN;
      end
      if (integral_clamp != '0) begin
        if (integ > longint'(integral_clamp)) integ = longint'(integral_clamp);
        if (integ < -longint'(integral_clamp)) integ = -longint'(integral_clamp);
      end
      if (used) iterm = longint'($signed(ki_gain)) * integ;
    end
    raw = longint'($signed(kp_gain)) * e + iterm
        + longint'($signed(kd_gain)) * (e - longint'(prev_error));
    drv = raw >>> GAIN_FRAC_BITS_DEF;   // floor
    if (drive_clamp != '0) begin
      if (drv > longint'(drive_clamp)) drv = longint'(drive_clamp);
      if (drv < -longint'(drive_clamp)) drv = -longint'(drive_clamp);
    end else begin
      if (drv > S32_MAX) drv = S32_MAX;
      if (drv < S32_MIN) drv = S32_MIN;
    end
    integral_sum = integ[INTEG_W-1:0];
    prev_error = sample;
    r.drive = drv[DRIVE_W-1:0];
    r.integral_used = used;
    drive_due.push_back(r);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return GAIN_W'($urandom_range(1, 512));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KP:     kp_gain = val[GAIN_W-1:0];
      REG_KI:     ki_gain = val[GAIN_W-1:0];
      REG_KD:     kd_gain = val[GAIN_W-1:0];
      REG_ICLAMP: integral_clamp = val[CLAMP_W-1:0];
      REG_DCLAMP: drive_clamp = val[CLAMP_W-1:0];
      REG_BAND:   separation_band = val[BAND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (error_backlog.size() != 0 || s_tvalid || drive_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) pid_predict(s_tdata[ERR_W-1:0]);
      if (!s_tvalid || s_tready) begin
        if (error_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          s_tdata  <= ERR_BUS_W'(error_backlog.pop_front());
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : result_monitor
    pid_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_due.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction drive=%h used=%b",
                                    m_tdata, m_tuser));
        end else begin
          want = drive_due.pop_front();
          if (m_tdata !== want.drive)
            report_mismatch($sformatf("drive %h, want %h", m_tdata, want.drive));
          if (m_tuser !== want.integral_used)
            report_mismatch($sformatf("integral_used %b, want %b", m_tuser, want.integral_used));
        end
      end
      if (stall_req) stall_left = STALL_CYCLES;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int               v;
    int               lim;
    logic [ERR_W-1:0] last_err;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // registers at reset value
    error_backlog.push_back(16'h7FFF);
    error_backlog.push_back(16'h8000);
    wait_drained();

    // full-scale gains, integrate always, no clamps
    write_reg(REG_KP, 32'h0000_7FFF);
    write_reg(REG_KI, 32'h0000_8000);
    write_reg(REG_KD, 32'h0000_7FFF);
    write_reg(REG_ICLAMP, 32'h0);
    write_reg(REG_DCLAMP, 32'h0);
    write_reg(REG_BAND, 32'h0);
    error_backlog.push_back(16'h7FFF);
    error_backlog.push_back(16'h8000);
    error_backlog.push_back(16'h0000);
    error_backlog.push_back(16'hFFFF);
    error_backlog.push_back(16'h0001);
    wait_drained();

    // separation band edges, both clamps active
    write_reg(REG_KI, 32'h0000_0100);
    write_reg(REG_BAND, 32'd100);
    write_reg(REG_ICLAMP, 32'd1000);
    write_reg(REG_DCLAMP, 32'd5000);
    error_backlog.push_back(16'd100);
    error_backlog.push_back(16'd101);
    error_backlog.push_back(-16'sd100);
    error_backlog.push_back(-16'sd101);
    error_backlog.push_back(16'h8000);
    wait_drained();

    // integral path off
    write_reg(REG_KI, 32'h0);
    error_backlog.push_back(16'd7);
    error_backlog.push_back(-16'sd7);
    wait_drained();

    // masked writes, writes past the register map, floor rounding of the scaling
    write_reg(REG_KP, 32'hFFFF_0001);
    write_reg(REG_KD, 32'hABCD_0000);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    write_reg(REG_ICLAMP, 32'hFFFF_FFFF);
    write_reg(REG_DCLAMP, 32'h8000_0000);
    write_reg(REG_BAND, 32'hFFFF_8000);
    error_backlog.push_back(16'hFFFF);
    error_backlog.push_back(16'd255);
    error_backlog.push_back(-16'sd255);
    error_backlog.push_back(-16'sd256);
    error_backlog.push_back(16'd256);
    wait_drained();

    // negative extremes of the kp and kd gains, tightest band and integral clamp
    write_reg(REG_KP, 32'h0000_8000);
    write_reg(REG_KI, 32'h0000_7FFF);
    write_reg(REG_KD, 32'h0000_8000);
    write_reg(REG_ICLAMP, 32'd1);
    write_reg(REG_DCLAMP, 32'h7FFF_FFFF);
    write_reg(REG_BAND, 32'd1);
    error_backlog.push_back(16'd1);
    error_backlog.push_back(16'hFFFF);
    error_backlog.push_back(16'd2);
    error_backlog.push_back(16'h8000);
    error_backlog.push_back(16'h7FFF);
    wait_drained();

    // full-scale errors drive the integral up then down; no idling for the whole stretch
    write_reg(REG_KP, 32'h0);
    write_reg(REG_KD, 32'h0);
    write_reg(REG_ICLAMP, 32'h0);
    write_reg(REG_DCLAMP, 32'h0);
    write_reg(REG_BAND, 32'h0);
    idle_pct <= 0;
    repeat (40) error_backlog.push_back(16'h7FFF);
    repeat (40) error_backlog.push_back(16'h8000);
    wait_drained();
    idle_pct <= 26;

    last_err = '0;
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_KP, {16'($urandom), pick_gain()});
      write_reg(REG_KI, ($urandom_range(0, 4) == 0) ? 32'h0 : {16'($urandom), pick_gain()});
      write_reg(REG_KD, {16'($urandom), pick_gain()});
      case ($urandom_range(0, 4))
        0: write_reg(REG_ICLAMP, 32'h0);
        1: write_reg(REG_ICLAMP, $urandom_range(1, 5000));
        2: write_reg(REG_ICLAMP, 32'h7FFF_FFFF);
        3: write_reg(REG_ICLAMP, $urandom);
        default: write_reg(REG_ICLAMP, $urandom_range(1, 1 << 20));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(REG_DCLAMP, 32'h0);
        1: write_reg(REG_DCLAMP, $urandom_range(1, 1000));
        2: write_reg(REG_DCLAMP, 32'h7FFF_FFFF);
        3: write_reg(REG_DCLAMP, $urandom);
        default: write_reg(REG_DCLAMP, $urandom_range(1, 1 << 24));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(REG_BAND, 32'h0);
        1: write_reg(REG_BAND, 32'd32768);
        2: write_reg(REG_BAND, $urandom_range(1, 64));
        3: write_reg(REG_BAND, $urandom_range(1, 4000));
        default: write_reg(REG_BAND, $urandom);
      endcase

      lim = (separation_band == '0 || separation_band > 32768) ? 32768 : int'(separation_band);
      for (int k = 0; k < 45; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: v = $urandom_range(0, lim);
          3: v = ($urandom_range(0, 1) != 0) ? lim : lim + 1;
          4, 5: begin
            case ($urandom_range(0, 4))
              0: v = 32767;
              1: v = -32768;
              2: v = 0;
              3: v = 1;
              default: v = -1;
            endcase
          end
          6, 7: v = $signed(last_err);   // runs push the integral toward its limits
          default: v = $signed(16'($urandom));
        endcase
        if (v >= 0 && $urandom_range(0, 1) != 0) v = -v;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        last_err = v[ERR_W-1:0];
        error_backlog.push_back(last_err);
      end
      // hold the result side off while the sender keeps offering
      if (p == 3) begin
        @(posedge clk);
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && drive_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
